/* rtl/plate_fissureness_voxel_top_defines.svh */
// assertion macros for the fissureness voxel block
`ifndef PLATE_FISSURENESS_VOXEL_TOP_DEFINES_SVH
`define PLATE_FISSURENESS_VOXEL_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PFV_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("pfv assertion failed");
`define PFV_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("pfv assertion failed");
`else
`define PFV_ASSERT(lbl, clk, rst_n, prop)
`define PFV_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* rtl/pfv_pkg.sv */
package pfv_pkg;

	localparam int INT_W      = 13;
	localparam int SPREAD_W   = 12;
	localparam int SCORE_W    = 16;
	localparam int DIST_W     = 13;
	localparam int QUO_BITS   = 17;
	localparam int EXP_SQUARINGS = 20;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MEAN   = 8'd0,
		CFG_SPREAD = 8'd1
	} cfg_reg_t;

endpackage

/* rtl/plate_fissureness_voxel_top.sv */
// plate-likeness fissure score for one CT voxel per clock
// input: start with voxel_intensity and eigen_first/second/third; an item is
//   taken at each rising edge with start high and busy low. busy stays low, so
//   a new voxel may be offered in every cycle.
// config: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is the
//   intensity mean, index 1 the intensity spread. cfg_ready is always high.
//   write registers only while no voxel is in flight.
// output: done strobes for one cycle with fissure_score (signed Q1.15) and
//   zero_denominator; the receiver must take it then.
// throughput: one voxel per cycle.
// the latency is set by two 17-step restoring dividers run side by side, one
//   quotient bit per stage, plus input, square, dividend setup, exp table,
//   product and output stages.
// the exp table is a constant ROM of EXP_TABLE_DEPTH entries with a
//   registered read.
// reset clears the valid pipeline and loads mean -850 and spread 100.
`include "plate_fissureness_voxel_top_defines.svh"
module plate_fissureness_voxel_top #(
	parameter int EIG_WIDTH       = 24,
	parameter int EXP_TABLE_DEPTH = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [pfv_pkg::INT_W-1:0]     voxel_intensity,
	input  logic signed [EIG_WIDTH-1:0]          eigen_first,
	input  logic signed [EIG_WIDTH-1:0]          eigen_second,
	input  logic signed [EIG_WIDTH-1:0]          eigen_third,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pfv_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pfv_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic                                 done,
	output logic signed [pfv_pkg::SCORE_W-1:0]   fissure_score,
	output logic                                 zero_denominator
);

	localparam int QB    = pfv_pkg::QUO_BITS;
	localparam int EW    = EIG_WIDTH;
	localparam int DENW  = EW + 1;
	localparam int PRW   = EW + QB + 2;
	localparam int D2W   = 2 * pfv_pkg::DIST_W;
	localparam int SD2W  = 2 * pfv_pkg::SPREAD_W;
	localparam int IDW   = SD2W + 5;
	localparam int NW    = D2W + $clog2(EXP_TABLE_DEPTH + 1);
	localparam int IRW   = ((IDW + QB) > NW ? (IDW + QB) : NW) + 1;
	localparam int IDXW  = $clog2(EXP_TABLE_DEPTH);
	localparam int LAT   = QB + 6;
	localparam int SW    = pfv_pkg::SCORE_W;

	function automatic logic [15:0] exp_entry(input int unsigned idx);
		logic [127:0] t;
		logic [127:0] b;
		if (idx == 0) begin
			return 16'h8000;
		end
		t = (128'(idx) << 36) / EXP_TABLE_DEPTH;
		b = (128'd1 << 32) - (t >> pfv_pkg::EXP_SQUARINGS);
		for (int k = 0; k < pfv_pkg::EXP_SQUARINGS; k++) begin
			b = (b * b + (128'd1 << 31)) >> 32;
		end
		return 16'((b + (128'd1 << 16)) >> 17);
	endfunction

	logic [15:0] exp_rom [EXP_TABLE_DEPTH];
	for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_rom
		assign exp_rom[g] = exp_entry(g);
	end

	// configuration
	logic signed [pfv_pkg::INT_W-1:0]  mean_q;
	logic [pfv_pkg::SPREAD_W-1:0]      spread_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q   <= -13'sd850;
			spread_q <= 12'd100;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pfv_pkg::CFG_MEAN:   mean_q   <= cfg_data[pfv_pkg::INT_W-1:0];
				pfv_pkg::CFG_SPREAD: spread_q <= cfg_data[pfv_pkg::SPREAD_W-1:0];
				default: ;
			endcase
		end
	end

	// valid pipeline
	logic [LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start && !busy};
		end
	end
	assign done = vld_q[LAT-1];

	// stage 1: magnitudes and intensity distance
	logic signed [pfv_pkg::INT_W:0] vdiff;
	logic [pfv_pkg::DIST_W-1:0]     dist_s1;
	logic [EW-1:0]                  a1_s1, a2_s1, a3_s1;
	logic [pfv_pkg::SPREAD_W-1:0]   sd_s1;

	assign vdiff = (pfv_pkg::INT_W+1)'(voxel_intensity) - (pfv_pkg::INT_W+1)'(mean_q);

	always_ff @(posedge clk) begin
		dist_s1 <= vdiff[pfv_pkg::INT_W] ? pfv_pkg::DIST_W'(-vdiff)
			: pfv_pkg::DIST_W'(vdiff);
		a1_s1 <= eigen_first[EW-1] ? EW'(-eigen_first) : EW'(eigen_first);
		a2_s1 <= eigen_second[EW-1] ? EW'(-eigen_second) : EW'(eigen_second);
		a3_s1 <= eigen_third[EW-1] ? EW'(-eigen_third) : EW'(eigen_third);
		sd_s1 <= (spread_q == '0) ? pfv_pkg::SPREAD_W'(1) : spread_q;
	end

	// stage 2: denominator, difference, squares
	logic [EW-1:0]   mx;
	logic [DENW-1:0] den_s2;
	logic [EW-1:0]   diff_s2;
	logic            pneg_s2;
	logic [D2W-1:0]  d2_s2;
	logic [SD2W-1:0] sd2_s2;

	assign mx = (a1_s1 > a2_s1) ? a1_s1 : a2_s1;

	always_ff @(posedge clk) begin
		den_s2  <= DENW'(a3_s1) + DENW'(mx);
		pneg_s2 <= a3_s1 < mx;
		diff_s2 <= (a3_s1 < mx) ? (mx - a3_s1) : (a3_s1 - mx);
		d2_s2   <= D2W'(dist_s1) * D2W'(dist_s1);
		sd2_s2  <= SD2W'(sd_s1) * SD2W'(sd_s1);
	end

	// stage 3: dividend setup and range check
	logic [IRW-1:0] nval, dval;
	assign nval = IRW'(d2_s2) * IRW'(EXP_TABLE_DEPTH);
	assign dval = IRW'(sd2_s2) << 5;

	logic [PRW-1:0]  prem_s [QB+1];
	logic [DENW-1:0] pden_s [QB+1];
	logic [QB-1:0]   pq_s   [QB+1];
	logic [IRW-1:0]  irem_s [QB+1];
	logic [IDW-1:0]  iden_s [QB+1];
	logic [QB-1:0]   iq_s   [QB+1];
	logic            pneg_s [QB+1];
	logic            zden_s [QB+1];
	logic            big_s  [QB+1];

	always_ff @(posedge clk) begin
		prem_s[0] <= (PRW'(diff_s2) << 15) + PRW'(den_s2 >> 1);
		pden_s[0] <= den_s2;
		pq_s[0]   <= '0;
		irem_s[0] <= nval;
		iden_s[0] <= IDW'(dval);
		iq_s[0]   <= '0;
		pneg_s[0] <= pneg_s2;
		zden_s[0] <= den_s2 == '0;
		big_s[0]  <= nval >= (dval << QB);
	end

	// divider stages, one quotient bit each
	for (genvar j = 0; j < QB; j++) begin : g_div
		localparam int K = QB - 1 - j;
		logic [PRW-1:0] pshf;
		logic [IRW-1:0] ishf;
		assign pshf = PRW'(pden_s[j]) << K;
		assign ishf = IRW'(iden_s[j]) << K;
		always_ff @(posedge clk) begin
			pden_s[j+1] <= pden_s[j];
			iden_s[j+1] <= iden_s[j];
			pneg_s[j+1] <= pneg_s[j];
			zden_s[j+1] <= zden_s[j];
			big_s[j+1]  <= big_s[j];
			if (prem_s[j] >= pshf) begin
				prem_s[j+1] <= prem_s[j] - pshf;
				pq_s[j+1]   <= pq_s[j] | (QB'(1) << K);
			end else begin
				prem_s[j+1] <= prem_s[j];
				pq_s[j+1]   <= pq_s[j];
			end
			if (irem_s[j] >= ishf) begin
				irem_s[j+1] <= irem_s[j] - ishf;
				iq_s[j+1]   <= iq_s[j] | (QB'(1) << K);
			end else begin
				irem_s[j+1] <= irem_s[j];
				iq_s[j+1]   <= iq_s[j];
			end
		end
	end

	// table read
	logic [15:0] w_sr;
	logic [15:0] pmag_sr;
	logic        pneg_sr, zden_sr;

	always_ff @(posedge clk) begin
		if (big_s[QB] || (iq_s[QB] >= QB'(EXP_TABLE_DEPTH))) begin
			w_sr <= '0;
		end else begin
			w_sr <= exp_rom[iq_s[QB][IDXW-1:0]];
		end
		pmag_sr <= pq_s[QB][15:0];
		pneg_sr <= pneg_s[QB];
		zden_sr <= zden_s[QB];
	end

	// product
	logic [31:0] prod_sm;
	logic        pneg_sm, zden_sm;
	always_ff @(posedge clk) begin
		prod_sm <= 32'(pmag_sr) * 32'(w_sr);
		pneg_sm <= pneg_sr;
		zden_sm <= zden_sr;
	end

	// rounding, sign, saturation
	logic [32:0] rnd;
	logic [17:0] smag;
	assign rnd  = 33'(prod_sm) + 33'd16384;
	assign smag = rnd[32:15];

	always_ff @(posedge clk) begin
		zero_denominator <= zden_sm;
		if (zden_sm) begin
			fissure_score <= '0;
		end else if (pneg_sm) begin
			fissure_score <= SW'(-smag);
		end else if (smag > 18'd32767) begin
			fissure_score <= 16'sh7fff;
		end else begin
			fissure_score <= SW'(smag);
		end
	end

	`PFV_ASSERT(a_latency, clk, arst_n, done |-> $past(start, LAT))
	`PFV_ASSERT(a_zden_score, clk, arst_n, (done && zero_denominator) |-> (fissure_score == '0))
	`PFV_ASSERT_ALWAYS(a_no_hold, clk, !busy && cfg_ready)

endmodule
